>>> src/ffra_pkg.sv
`default_nettype none
package ffra_pkg;

    localparam int OP_W       = 2;
    localparam int OWNER_W    = 8;
    localparam int SIZE_W     = 32;
    localparam int INDEX_W    = 9;
    localparam int STATUS_W   = 2;
    localparam int ADDR_OUT_W = 32;
    localparam int CFG_W      = 32;

    localparam logic [CFG_W-1:0] RESET_BASE   = 32'd131072;
    localparam logic [CFG_W-1:0] RESET_LENGTH = 32'd393216;

    localparam logic CFG_REGION_BASE   = 1'b0;
    localparam logic CFG_REGION_LENGTH = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_NO_DESC  = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_SCAN,
        S_A_ADD,
        S_A_SUB,
        S_A_WCUR,
        S_A_WPREV,
        S_F_RDB,
        S_F_CHKB,
        S_F_RD,
        S_F_CHK,
        S_F_SUMB,
        S_F_MRGN,
        S_F_SUMP,
        S_F_MRGP,
        S_F_WBLK,
        S_F_WPREV,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

>>> src/first_fit_region_allocator_top.sv
`default_nettype none
// First-fit region allocator. A descriptor table (start, length, owner, link, in-use) in
// block RAM tracks one address region; free regions form an address-ordered list
// from a head pointer. Start a request with start high while busy is low; the result
// word appears on status, granted_index and granted_address for exactly one cycle with
// done high, and the receiver cannot stall it. Timing is set by the single RAM read
// port and the one shared add/subtract unit: an allocate walks the free regions and then
// scans the descriptors for an unused one; a free walks the free regions and then merges;
// a reinitialize reruns the clearing pass. After reset the block runs a clearing pass over
// every descriptor with busy high and gives no result. Configuration writes are
// always taken (cfg_ready is tied high) and apply at the next reinitialize.
module first_fit_region_allocator_top #(
    parameter int DESCRIPTOR_COUNT = 512,
    parameter int ADDRESS_BITS     = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [ffra_pkg::OP_W-1:0]           operation,
    input  wire logic [ffra_pkg::OWNER_W-1:0]        owner_id,
    input  wire logic [ffra_pkg::SIZE_W-1:0]         request_size,
    input  wire logic [ffra_pkg::INDEX_W-1:0]        block_index,
    output logic                                     done,
    output logic      [ffra_pkg::STATUS_W-1:0]       status,
    output logic      [ffra_pkg::INDEX_W-1:0]        granted_index,
    output logic      [ffra_pkg::ADDR_OUT_W-1:0]     granted_address,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [ffra_pkg::CFG_W-1:0]          cfg_data
);

    import ffra_pkg::*;

    localparam int IDXW = $clog2(DESCRIPTOR_COUNT);
    localparam int LW   = IDXW + 1;
    localparam int AW   = ADDRESS_BITS;
    localparam int MW   = OWNER_W + LW + 1;
    localparam logic [LW-1:0] LIST_END = LW'(DESCRIPTOR_COUNT);
    localparam logic [LW-1:0] LAST_IDX = LW'(DESCRIPTOR_COUNT - 1);

    state_t state_reg, state_next;

    // RAM ports
    logic            ram_we;
    logic [IDXW-1:0] ram_waddr, ram_raddr;
    logic [AW-1:0]   w_start, w_len, r_start, r_len;
    logic [MW-1:0]   w_meta, r_meta;
    logic [OWNER_W-1:0] r_owner;
    logic [LW-1:0]   r_link;
    logic            r_inuse;

    // shared adder
    logic [AW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_borrow;

    // control
    logic [LW-1:0]   clr_reg;
    logic            clr_reply_reg;
    logic [IDXW-1:0] head_reg;
    logic [CFG_W-1:0] base_reg, length_reg;

    // request and walk
    logic [OWNER_W-1:0] owner_reg;
    logic [AW-1:0]   size_reg;
    logic [IDXW-1:0] blk_reg;
    logic [LW-1:0]   cur_reg, prev_reg, steps_reg, scan_reg;
    logic            scan_pv_reg;
    logic [IDXW-1:0] scan_idx_reg, fresh_reg;

    logic [AW-1:0]      cur_start_reg, cur_len_reg;
    logic [OWNER_W-1:0] cur_owner_reg;
    logic [LW-1:0]      cur_link_reg;
    logic               cur_inuse_reg;
    logic [AW-1:0]      prev_start_reg, prev_len_reg;
    logic [OWNER_W-1:0] prev_owner_reg;
    logic [LW-1:0]      prev_link_reg;
    logic               prev_inuse_reg;
    logic [AW-1:0]      blk_start_reg, blk_len_reg;
    logic [LW-1:0]      blk_link_reg;
    logic               blk_inuse_reg;
    logic [AW-1:0]      nstart_reg, nlen_reg, sum_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [IDXW-1:0]     gidx_reg;
    logic [AW-1:0]       gaddr_reg;

    // decoded conditions
    logic cur_valid, prev_valid, walk_limit, blk_in_range;
    logic scan_hit, scan_end, unlink, merge_next, merge_prev, bad_blk;
    op_t  op_in;

    assign op_in        = op_t'(operation);
    assign r_owner      = r_meta[MW-1 -: OWNER_W];
    assign r_link       = r_meta[1 +: LW];
    assign r_inuse      = r_meta[0];
    assign cur_valid    = cur_reg < LIST_END;
    assign prev_valid   = prev_reg < LIST_END;
    assign walk_limit   = steps_reg == LIST_END;
    assign blk_in_range = 32'(block_index) < 32'(DESCRIPTOR_COUNT);
    assign scan_hit     = scan_pv_reg && !r_inuse;
    assign scan_end     = scan_reg == LIST_END;
    assign unlink       = (nlen_reg == '0) && (cur_reg != LW'(head_reg)) && prev_valid;
    assign merge_next   = cur_valid && (sum_reg == cur_start_reg);
    assign merge_prev   = prev_valid && (sum_reg == blk_start_reg);
    assign bad_blk      = !r_inuse || (r_owner == '0);

    // one RAM per field group, sharing address and write enable
    ffra_ram #(.WIDTH(AW), .DEPTH(DESCRIPTOR_COUNT)) u_start_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(w_start),
        .raddr(ram_raddr), .rdata(r_start)
    );

    ffra_ram #(.WIDTH(AW), .DEPTH(DESCRIPTOR_COUNT)) u_len_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(w_len),
        .raddr(ram_raddr), .rdata(r_len)
    );

    ffra_ram #(.WIDTH(MW), .DEPTH(DESCRIPTOR_COUNT)) u_meta_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(w_meta),
        .raddr(ram_raddr), .rdata(r_meta)
    );

    ffra_alu #(.W(AW)) u_alu (
        .a(alu_a), .b(alu_b), .sub(alu_sub), .result(alu_sum), .borrow(alu_borrow)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                begin
                    state_next = clr_reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (op_in)
                        OP_ALLOC: state_next = S_A_RD;
                        OP_FREE:  state_next = blk_in_range ? S_F_RDB : S_DONE;
                        OP_INIT:  state_next = S_CLEAR;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_A_RD:    state_next = cur_valid ? S_A_CHK : S_DONE;
            S_A_CHK:
            begin
                if (walk_limit)
                begin
                    state_next = S_DONE;
                end
                else if (alu_borrow)
                begin
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_A_SCAN;
                end
            end
            S_A_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_A_ADD;
                end
                else if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_A_ADD:   state_next = S_A_SUB;
            S_A_SUB:   state_next = S_A_WCUR;
            S_A_WCUR:  state_next = unlink ? S_A_WPREV : S_DONE;
            S_A_WPREV: state_next = S_DONE;
            S_F_RDB:   state_next = S_F_CHKB;
            S_F_CHKB:  state_next = bad_blk ? S_DONE : S_F_RD;
            S_F_RD:    state_next = cur_valid ? S_F_CHK : S_F_SUMB;
            S_F_CHK:   state_next = (!walk_limit && alu_borrow) ? S_F_RD : S_F_SUMB;
            S_F_SUMB:  state_next = S_F_MRGN;
            S_F_MRGN:  state_next = S_F_SUMP;
            S_F_SUMP:  state_next = S_F_MRGP;
            S_F_MRGP:  state_next = S_F_WBLK;
            S_F_WBLK:  state_next = S_F_WPREV;
            S_F_WPREV: state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // RAM and adder controls
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_raddr = '0;
        w_start   = '0;
        w_len     = '0;
        w_meta    = '0;
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                // entry zero takes the whole region, all others go unused
                ram_we    = 1'b1;
                ram_waddr = clr_reg[IDXW-1:0];
                if (clr_reg == '0)
                begin
                    w_start = AW'(base_reg);
                    w_len   = AW'(length_reg);
                end
                w_meta = {{OWNER_W{1'b0}}, LIST_END, clr_reg == '0};
            end
            S_A_RD, S_F_RD:
            begin
                ram_raddr = cur_reg[IDXW-1:0];
            end
            S_A_CHK:
            begin
                alu_a   = r_len;
                alu_b   = size_reg;
                alu_sub = 1'b1;
            end
            S_A_SCAN:
            begin
                ram_raddr = scan_reg[IDXW-1:0];
            end
            S_A_ADD:
            begin
                ram_we    = 1'b1;
                ram_waddr = fresh_reg;
                w_start   = cur_start_reg;
                w_len     = size_reg;
                w_meta    = {owner_reg, LIST_END, 1'b1};
                alu_a     = cur_start_reg;
                alu_b     = size_reg;
            end
            S_A_SUB:
            begin
                alu_a   = cur_len_reg;
                alu_b   = size_reg;
                alu_sub = 1'b1;
            end
            S_A_WCUR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg[IDXW-1:0];
                w_start   = nstart_reg;
                w_len     = nlen_reg;
                w_meta    = {cur_owner_reg, unlink ? LIST_END : cur_link_reg,
                             unlink ? 1'b0 : cur_inuse_reg};
            end
            S_A_WPREV:
            begin
                // bridge over the emptied region
                ram_we    = 1'b1;
                ram_waddr = prev_reg[IDXW-1:0];
                w_start   = prev_start_reg;
                w_len     = prev_len_reg;
                w_meta    = {prev_owner_reg, cur_link_reg, prev_inuse_reg};
            end
            S_F_RDB:
            begin
                ram_raddr = blk_reg;
            end
            S_F_CHK:
            begin
                alu_a   = r_start;
                alu_b   = blk_start_reg;
                alu_sub = 1'b1;
            end
            S_F_SUMB:
            begin
                alu_a = blk_start_reg;
                alu_b = blk_len_reg;
            end
            S_F_MRGN:
            begin
                alu_a = blk_len_reg;
                alu_b = cur_len_reg;
                if (merge_next)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg[IDXW-1:0];
                    w_start   = cur_start_reg;
                    w_len     = cur_len_reg;
                    w_meta    = {cur_owner_reg, LIST_END, 1'b0};
                end
            end
            S_F_SUMP:
            begin
                alu_a = prev_start_reg;
                alu_b = prev_len_reg;
            end
            S_F_MRGP:
            begin
                alu_a = prev_len_reg;
                alu_b = blk_len_reg;
            end
            S_F_WBLK:
            begin
                ram_we    = 1'b1;
                ram_waddr = blk_reg;
                w_start   = blk_start_reg;
                w_len     = blk_len_reg;
                w_meta    = {{OWNER_W{1'b0}}, blk_link_reg, blk_inuse_reg};
            end
            S_F_WPREV:
            begin
                ram_we    = prev_valid;
                ram_waddr = prev_reg[IDXW-1:0];
                w_start   = prev_start_reg;
                w_len     = prev_len_reg;
                w_meta    = {prev_owner_reg, prev_link_reg, prev_inuse_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clr_reply_reg <= 1'b0;
            head_reg      <= '0;
            base_reg      <= RESET_BASE;
            length_reg    <= RESET_LENGTH;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
            begin
                clr_reg       <= '0;
                clr_reply_reg <= 1'b1;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg  <= clr_reg + LW'(1);
                head_reg <= '0;
            end
            if (state_reg == S_F_MRGP && !prev_valid)
            begin
                head_reg <= blk_reg;
            end
            if (cfg_valid)
            begin
                if (cfg_index == CFG_REGION_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else if (cfg_index == CFG_REGION_LENGTH)
                begin
                    length_reg <= cfg_data;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    owner_reg   <= owner_id;
                    size_reg    <= AW'(request_size);
                    blk_reg     <= IDXW'(block_index);
                    cur_reg     <= LW'(head_reg);
                    prev_reg    <= LIST_END;
                    steps_reg   <= '0;
                    scan_reg    <= '0;
                    scan_pv_reg <= 1'b0;
                    gidx_reg    <= '0;
                    gaddr_reg   <= '0;
                    status_reg  <= (op_in == OP_FREE && !blk_in_range) ? ST_BAD_FREE : ST_OK;
                end
            end
            S_A_RD:
            begin
                if (!cur_valid)
                begin
                    status_reg <= ST_NO_FIT;
                end
            end
            S_A_CHK, S_F_CHK:
            begin
                cur_start_reg <= r_start;
                cur_len_reg   <= r_len;
                cur_owner_reg <= r_owner;
                cur_link_reg  <= r_link;
                cur_inuse_reg <= r_inuse;
                if (state_reg == S_A_CHK && walk_limit)
                begin
                    status_reg <= ST_NO_FIT;
                end
                else if (!walk_limit && alu_borrow)
                begin
                    // advance one node
                    prev_reg       <= cur_reg;
                    prev_start_reg <= r_start;
                    prev_len_reg   <= r_len;
                    prev_owner_reg <= r_owner;
                    prev_link_reg  <= r_link;
                    prev_inuse_reg <= r_inuse;
                    cur_reg        <= r_link;
                    steps_reg      <= steps_reg + LW'(1);
                end
            end
            S_A_SCAN:
            begin
                if (scan_hit)
                begin
                    fresh_reg <= scan_idx_reg;
                end
                else if (scan_end)
                begin
                    status_reg <= ST_NO_DESC;
                end
                else
                begin
                    scan_idx_reg <= scan_reg[IDXW-1:0];
                    scan_pv_reg  <= 1'b1;
                    scan_reg     <= scan_reg + LW'(1);
                end
            end
            S_A_ADD:
            begin
                nstart_reg <= alu_sum;
            end
            S_A_SUB:
            begin
                nlen_reg   <= alu_sum;
                status_reg <= ST_OK;
                gidx_reg   <= fresh_reg;
                gaddr_reg  <= cur_start_reg;
            end
            S_F_CHKB:
            begin
                blk_start_reg <= r_start;
                blk_len_reg   <= r_len;
                blk_inuse_reg <= r_inuse;
                if (bad_blk)
                begin
                    status_reg <= ST_BAD_FREE;
                end
            end
            S_F_RD:
            begin
                if (!cur_valid)
                begin
                    cur_reg <= LIST_END;
                end
            end
            S_F_SUMB, S_F_SUMP:
            begin
                sum_reg <= alu_sum;
            end
            S_F_MRGN:
            begin
                if (merge_next)
                begin
                    blk_len_reg  <= alu_sum;
                    blk_link_reg <= cur_link_reg;
                end
                else
                begin
                    blk_link_reg <= cur_reg;
                end
            end
            S_F_MRGP:
            begin
                if (merge_prev)
                begin
                    // absorb the block into the region before it
                    prev_len_reg  <= alu_sum;
                    prev_link_reg <= blk_link_reg;
                    blk_inuse_reg <= 1'b0;
                    blk_link_reg  <= LIST_END;
                end
                else if (prev_valid)
                begin
                    prev_link_reg <= LW'(blk_reg);
                end
            end
            default:
            begin
                scan_pv_reg <= scan_pv_reg;
            end
        endcase
    end

    assign busy            = state_reg != S_IDLE;
    assign done            = state_reg == S_DONE;
    assign status          = status_reg;
    assign granted_index   = INDEX_W'(gidx_reg);
    assign granted_address = ADDR_OUT_W'(gaddr_reg);
    assign cfg_ready       = 1'b1;

    // a result word always releases the block in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("block stayed busy after result");

    // an accepted request always starts work
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // walk counter never runs past the table size while a walk compares
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_CHK || state_reg == S_F_CHK) |-> steps_reg <= LIST_END)
        else $error("list walk overran");

    // no table writes while idle
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == S_IDLE) |-> !ram_we)
        else $error("table write while idle");

endmodule
`default_nettype wire

>>> src/ffra_ram.sv
`default_nettype none
module ffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> src/ffra_alu.sv
`default_nettype none
module ffra_alu #(
    parameter int W = 32
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic         sub,
    output logic      [W-1:0] result,
    output logic              borrow
);

    logic [W:0] sum;

    // subtract as a plus inverted b plus one
    assign sum    = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
    assign result = sum[W-1:0];
    assign borrow = sub & ~sum[W];

endmodule
`default_nettype wire

>>> sim/first_fit_region_allocator_checker.sv
`timescale 1ns / 1ps
module first_fit_region_allocator_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic [ffra_pkg::OP_W-1:0]       operation,
    input  wire logic [ffra_pkg::OWNER_W-1:0]    owner_id,
    input  wire logic [ffra_pkg::SIZE_W-1:0]     request_size,
    input  wire logic [ffra_pkg::INDEX_W-1:0]    block_index,
    input  wire logic                            done,
    input  wire logic [ffra_pkg::STATUS_W-1:0]   status,
    input  wire logic [ffra_pkg::INDEX_W-1:0]    granted_index,
    input  wire logic [ffra_pkg::ADDR_OUT_W-1:0] granted_address,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [ffra_pkg::CFG_W-1:0]      cfg_data,
    output int                                   fail_count,
    output int                                   pending
);
    import ffra_pkg::*;

    localparam int NDESC = 512;
    localparam int NIL   = NDESC;

    typedef struct packed {
        status_t     st;
        logic [8:0]  idx;
        logic [31:0] addr;
    } grant_t;

    logic [31:0] base_q, len_q;
    logic [31:0] d_start [NDESC];
    logic [31:0] d_len   [NDESC];
    logic [7:0]  d_owner [NDESC];
    int          d_next  [NDESC];
    bit          d_used  [NDESC];
    int          head;
    grant_t      expected_grants[$];

    function automatic void rebuild();
        for (int i = 0; i < NDESC; i++)
        begin
            d_start[i] = '0;
            d_len[i]   = '0;
            d_owner[i] = '0;
            d_next[i]  = NIL;
            d_used[i]  = 1'b0;
        end
        d_start[0] = base_q;
        d_len[0]   = len_q;
        d_used[0]  = 1'b1;
        head       = 0;
    endfunction

    function automatic grant_t allocate(logic [7:0] own, logic [31:0] sz);
        grant_t g;
        int cur, prev, steps, fresh;
        g     = '{ST_OK, 9'd0, 32'd0};
        cur   = head;
        prev  = NIL;
        steps = 0;
        while (cur < NDESC && steps < NDESC && d_len[cur] < sz)
        begin
            prev = cur;
            cur  = d_next[cur];
            steps++;
        end
        if (cur >= NDESC || steps >= NDESC)
        begin
            g.st = ST_NO_FIT;
            return g;
        end
        fresh = NIL;
        for (int i = 0; i < NDESC; i++)
            if (!d_used[i] && fresh == NIL)
                fresh = i;
        if (fresh == NIL)
        begin
            g.st = ST_NO_DESC;
            return g;
        end
        d_used[fresh]  = 1'b1;
        d_next[fresh]  = NIL;
        d_owner[fresh] = own;
        d_len[fresh]   = sz;
        d_start[fresh] = d_start[cur];
        d_start[cur]   = d_start[cur] + sz;
        d_len[cur]     = d_len[cur] - sz;
        // drop an emptied region unless it is the head
        if (d_len[cur] == 0 && cur != head && prev < NDESC)
        begin
            d_next[prev] = d_next[cur];
            d_used[cur]  = 1'b0;
            d_next[cur]  = NIL;
        end
        g.idx  = fresh[8:0];
        g.addr = d_start[fresh];
        return g;
    endfunction

    function automatic status_t release_block(int blk);
        int cur, prev, steps;
        if (!d_used[blk] || d_owner[blk] == 0)
            return ST_BAD_FREE;
        prev  = NIL;
        cur   = head;
        steps = 0;
        while (cur < NDESC && steps < NDESC && d_start[blk] > d_start[cur])
        begin
            prev = cur;
            cur  = d_next[cur];
            steps++;
        end
        if (cur >= NDESC)
            cur = NIL;
        d_next[blk]  = cur;
        d_owner[blk] = '0;
        if (prev < NDESC)
            d_next[prev] = blk;
        else
            head = blk;
        if (cur < NDESC && d_start[blk] + d_len[blk] == d_start[cur])
        begin
            d_len[blk]  = d_len[blk] + d_len[cur];
            d_next[blk] = d_next[cur];
            d_used[cur] = 1'b0;
            d_next[cur] = NIL;
        end
        if (prev < NDESC && d_start[prev] + d_len[prev] == d_start[blk])
        begin
            d_len[prev]  = d_len[prev] + d_len[blk];
            d_next[prev] = d_next[blk];
            d_used[blk]  = 1'b0;
            d_next[blk]  = NIL;
        end
        return ST_OK;
    endfunction

    assign pending = expected_grants.size();

    always @(posedge clk or negedge rst_n)
    begin
        grant_t g, got;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_grants.delete();
            base_q = RESET_BASE;
            len_q  = RESET_LENGTH;
            rebuild();
        end
        else
        begin
            if (done)
            begin
                got = '{status_t'(status), granted_index, granted_address};
                if (expected_grants.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    g = expected_grants.pop_front();
                    if (g != got)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: exp st=%0d idx=%0d addr=%h ",
                                      "got st=%0d idx=%0d addr=%h"},
                                     g.st, g.idx, g.addr, got.st, got.idx, got.addr);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                g = '{ST_OK, 9'd0, 32'd0};
                case (op_t'(operation))
                    OP_ALLOC: g = allocate(owner_id, request_size);
                    OP_FREE:  g.st = release_block(int'(block_index));
                    OP_INIT:  rebuild();
                    default:  ;
                endcase
                expected_grants.push_back(g);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_REGION_BASE)
                    base_q = cfg_data;
                else
                    len_q = cfg_data;
            end
        end
    end
endmodule

>>> sim/first_fit_region_allocator_top_tb.sv
`timescale 1ns / 1ps
module first_fit_region_allocator_top_tb;
    import ffra_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       operation = OP_NONE;
    logic [OWNER_W-1:0]    owner_id = '0;
    logic [SIZE_W-1:0]     request_size = '0;
    logic [INDEX_W-1:0]    block_index = '0;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [INDEX_W-1:0]    granted_index;
    logic [ADDR_OUT_W-1:0] granted_address;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = CFG_REGION_BASE;
    logic [CFG_W-1:0]      cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    // indexes handed out lately; frees draw from here so merges happen
    logic [INDEX_W-1:0]    live_blocks[$];

    always #4 clk = ~clk;

    first_fit_region_allocator_top uut (.*);

    first_fit_region_allocator_checker chk (.*);

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Track granted descriptors so frees hit real blocks.
    always @(posedge clk)
        if (done && status == ST_OK && granted_index != 0)
            live_blocks.push_back(granted_index);

    // Hold the inputs idle for a random gap: mostly short, now and then long.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        repeat (n) @(negedge clk);
    endtask

    // Present one request word and hold it until the block takes it.
    task automatic issue(op_t op, logic [7:0] own, logic [31:0] sz, logic [8:0] blk);
        @(negedge clk);
        operation    = op;
        owner_id     = own;
        request_size = sz;
        block_index  = blk;
        start        = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start = 1'b0;
        idle_gap();
    endtask

    // Write a register only while the block is idle and nothing is owed.
    task automatic write_reg(logic idx, logic [31:0] val);
        while (pending != 0 || busy)
            @(negedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_free();
        int k;
        logic [8:0] blk;
        if (live_blocks.size() != 0 && $urandom_range(0, 7) != 0)
        begin
            k   = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[k];
            live_blocks.delete(k);
        end
        else
            blk = 9'($urandom_range(0, 511));
        issue(OP_FREE, 8'($urandom_range(0, 255)), '0, blk);
    endtask

    task automatic random_alloc();
        logic [31:0] sz;
        case ($urandom_range(0, 9))
            0:       sz = $urandom();
            1:       sz = 32'd0;
            2:       sz = 32'hFFFF_FFFF;
            default: sz = $urandom_range(1, 4096);
        endcase
        issue(OP_ALLOC, 8'($urandom_range(1, 255)), sz, 9'($urandom_range(0, 511)));
    endtask

    task automatic phase(logic [31:0] b, logic [31:0] l, int items);
        write_reg(CFG_REGION_BASE, b);
        write_reg(CFG_REGION_LENGTH, l);
        issue(OP_INIT, 8'($urandom()), $urandom(), 9'($urandom()));
        live_blocks.delete();
        for (int i = 0; i < items; i++)
        begin
            case ($urandom_range(0, 19))
                0:                     issue(OP_NONE, 8'($urandom()), $urandom(),
                                             9'($urandom()));
                1:                     issue(OP_INIT, 8'($urandom()), $urandom(),
                                             9'($urandom()));
                2, 3, 4, 5, 6, 7, 8:   random_free();
                default:               random_alloc();
            endcase
            if (live_blocks.size() == 0 && $urandom_range(0, 1) == 0)
                live_blocks.delete();
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset table, zero size, extremes, bad frees, wrap, op 3.
        issue(OP_ALLOC, 8'hFF, 32'd0, '0);
        issue(OP_ALLOC, 8'h01, 32'd4096, '0);
        issue(OP_ALLOC, 8'h00, 32'd16, '0);
        issue(OP_ALLOC, 8'h80, 32'hFFFF_FFFF, '0);
        issue(OP_FREE, 8'h00, '0, 9'd0);
        issue(OP_FREE, 8'h00, '0, 9'd511);
        issue(OP_FREE, 8'h00, '0, 9'd3);
        issue(OP_FREE, 8'h00, '0, 9'd2);
        issue(OP_FREE, 8'h00, '0, 9'd2);
        issue(OP_ALLOC, 8'h55, 32'h0002_0000, '0);
        issue(OP_ALLOC, 8'hAA, 32'h0006_0000, '0);
        issue(OP_FREE, 8'h00, '0, 9'd1);
        issue(OP_FREE, 8'h00, '0, 9'd3);
        issue(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 9'h1FF);

        // Wrapping region: base 16 below the top, all-ones length.
        write_reg(CFG_REGION_BASE, 32'hFFFF_FFF0);
        write_reg(CFG_REGION_LENGTH, 32'hFFFF_FFFF);
        issue(OP_INIT, '0, '0, '0);
        issue(OP_ALLOC, 8'h01, 32'h20, '0);
        issue(OP_ALLOC, 8'h02, 32'hFFFF_FFDF, '0);
        issue(OP_FREE, 8'h00, '0, 9'd1);
        issue(OP_FREE, 8'h00, '0, 9'd2);

        // Run out of descriptors: one-byte grabs until the table is full, then one more.
        write_reg(CFG_REGION_BASE, 32'd0);
        write_reg(CFG_REGION_LENGTH, 32'd600);
        issue(OP_INIT, '0, '0, '0);
        for (int i = 0; i < 512; i++)
            issue(OP_ALLOC, 8'h7F, 32'd1, '0);
        issue(OP_FREE, 8'h00, '0, 9'd100);
        issue(OP_FREE, 8'h00, '0, 9'd101);
        issue(OP_ALLOC, 8'h7F, 32'd2, '0);

        phase(RESET_BASE, RESET_LENGTH, 12);
        phase(32'd0, 32'd0, 3);
        phase(32'hFFFF_F000, 32'd65536, 8);
        phase($urandom(), $urandom(), 8);

        while (pending != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
src/ffra_pkg.sv
src/ffra_ram.sv
src/ffra_alu.sv
src/first_fit_region_allocator_top.sv
sim/first_fit_region_allocator_checker.sv
sim/first_fit_region_allocator_top_tb.sv
